/* rtl/core/fva_pkg.sv */
// Shared types and constants for the FM voice allocator.
// Used by fva_ctrl, fva_datapath and fm_voice_allocator_top; no dependencies.
`default_nettype none

package fva_pkg;

    localparam int VOICES    = 9;
    localparam int IDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AGE_W     = 32;
    localparam int NOTE_W    = 7;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [AGE_W-1:0]  age_t;
    typedef logic [NOTE_W-1:0] note_t;

    typedef enum logic [1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_ALL_OFF  = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_STOP    = 2'd1,
        ACT_SILENCE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0] kind;
        note_t      note;
    } in_word_t;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] voice;
        note_t      pitch;
        logic       stolen;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_CLEAR
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        logic clear;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/fva_ctrl.sv */
// Controller state machine of the FM voice allocator.
// Depends on fva_pkg; drives fva_datapath through cmd_t and reads status_t.
`default_nettype none

module fva_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     kind,
    input  fva_pkg::status_t    status,
    output fva_pkg::cmd_t       cmd,
    output logic                busy
);

    fva_pkg::state_t state_reg;
    fva_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fva_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fva_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (kind) inside
                        fva_pkg::KIND_NOTE_ON, fva_pkg::KIND_NOTE_OFF:
                            state_next = fva_pkg::ST_SCAN;
                        fva_pkg::KIND_ALL_OFF:
                            state_next = fva_pkg::ST_CLEAR;
                        default:
                            state_next = fva_pkg::ST_IDLE;
                    endcase
                end
            end
            fva_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = fva_pkg::ST_COMMIT;
                end
            end
            fva_pkg::ST_COMMIT: state_next = fva_pkg::ST_IDLE;
            fva_pkg::ST_CLEAR:  state_next = fva_pkg::ST_IDLE;
            default:            state_next = fva_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            fva_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            fva_pkg::ST_SCAN:   cmd.step   = 1'b1;
            fva_pkg::ST_COMMIT: cmd.commit = 1'b1;
            fva_pkg::ST_CLEAR:  cmd.clear  = 1'b1;
            default:            busy       = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/fva_datapath.sv */
// Voice table, scan registers and result register of the FM voice allocator.
// Depends on fva_pkg; commanded by fva_ctrl.
`default_nettype none

module fva_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  fva_pkg::in_word_t    cmd_word,
    input  fva_pkg::cmd_t        cmd,
    output fva_pkg::status_t     status,
    output fva_pkg::out_word_t   result,
    output logic                 done
);

    fva_pkg::note_t pitch_reg [fva_pkg::VOICES];
    logic           busy_reg  [fva_pkg::VOICES];
    fva_pkg::age_t  age_reg   [fva_pkg::VOICES];
    fva_pkg::age_t  clock_reg;

    fva_pkg::in_word_t  item_reg;
    fva_pkg::idx_t      idx_reg;
    logic               free_found_reg;
    fva_pkg::idx_t      free_idx_reg;
    fva_pkg::idx_t      min_idx_reg;
    fva_pkg::age_t      min_age_reg;
    logic               off_found_reg;
    fva_pkg::idx_t      off_idx_reg;
    fva_pkg::age_t      off_age_reg;

    fva_pkg::out_word_t result_reg;
    logic               done_reg;

    fva_pkg::note_t cur_pitch;
    logic           cur_busy;
    fva_pkg::age_t  cur_age;
    fva_pkg::idx_t  on_pick;
    fva_pkg::age_t  clock_inc;
    logic [31:0]    on_pick_wide;
    logic [31:0]    off_pick_wide;
    logic           is_on;

    assign cur_pitch     = pitch_reg[idx_reg];
    assign cur_busy      = busy_reg[idx_reg];
    assign cur_age       = age_reg[idx_reg];
    assign on_pick       = free_found_reg ? free_idx_reg : min_idx_reg;
    assign clock_inc     = clock_reg + fva_pkg::AGE_W'(1);
    assign on_pick_wide  = 32'(on_pick);
    assign off_pick_wide = 32'(off_idx_reg);
    assign is_on         = (item_reg.kind == fva_pkg::KIND_NOTE_ON);

    assign status.scan_last = (idx_reg == fva_pkg::idx_t'(fva_pkg::VOICES - 1));
    assign result           = result_reg;
    assign done             = done_reg;

    // voice table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fva_pkg::VOICES; i++)
            begin
                pitch_reg[i] <= '0;
                busy_reg[i]  <= 1'b0;
                age_reg[i]   <= '0;
            end
            clock_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < fva_pkg::VOICES; i++)
            begin
                pitch_reg[i] <= '0;
                busy_reg[i]  <= 1'b0;
                age_reg[i]   <= '0;
            end
            clock_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (is_on)
            begin
                clock_reg          <= clock_inc;
                pitch_reg[on_pick] <= item_reg.note;
                busy_reg[on_pick]  <= 1'b1;
                age_reg[on_pick]   <= clock_inc;
            end
            else if (off_found_reg)
            begin
                busy_reg[off_idx_reg] <= 1'b0;
            end
        end
    end

    // scan over the voices, one per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg       <= cmd_word;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            min_idx_reg    <= '0;
            min_age_reg    <= '0;
            off_found_reg  <= 1'b0;
            off_idx_reg    <= '0;
            off_age_reg    <= '0;
        end
        else if (cmd.step)
        begin
            if (!status.scan_last)
            begin
                idx_reg <= idx_reg + fva_pkg::IDX_W'(1);
            end
            if (!cur_busy && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            // voice 0 seeds the oldest; only a strictly smaller age replaces it
            if (idx_reg == '0 || cur_age < min_age_reg)
            begin
                min_idx_reg <= idx_reg;
                min_age_reg <= cur_age;
            end
            if (cur_busy && cur_pitch == item_reg.note && cur_age >= off_age_reg)
            begin
                off_found_reg <= 1'b1;
                off_idx_reg   <= idx_reg;
                off_age_reg   <= cur_age;
            end
        end
    end

    // result word, with done high for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.clear || (cmd.commit && (is_on || off_found_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            result_reg.action <= fva_pkg::ACT_SILENCE;
            result_reg.voice  <= '0;
            result_reg.pitch  <= '0;
            result_reg.stolen <= 1'b0;
        end
        else if (cmd.commit)
        begin
            result_reg.pitch <= item_reg.note;
            if (is_on)
            begin
                result_reg.action <= fva_pkg::ACT_START;
                result_reg.voice  <= on_pick_wide[3:0];
                result_reg.stolen <= !free_found_reg;
            end
            else
            begin
                result_reg.action <= fva_pkg::ACT_STOP;
                result_reg.voice  <= off_pick_wide[3:0];
                result_reg.stolen <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fm_voice_allocator_top.sv */
// Top level of the FM voice allocator: joins fva_ctrl and fva_datapath.
// Depends on fva_pkg.
`default_nettype none

// A note-on or note-off word is taken when start is high and busy is low; the
// block then scans the voice table one voice per cycle, holding busy high through
// the scan and the commit state before the next word can be taken.
// An all-notes-off word holds busy for one cycle. The result word appears on
// result with done high for exactly one cycle, the first cycle with busy low
// again, and cannot be held off: capture it when done is high. A note-off that
// matches no sounding voice, and a word of the unused kind, give no result.
module fm_voice_allocator_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  fva_pkg::in_word_t   cmd_word,
    output fva_pkg::out_word_t  result,
    output logic                done
);

    fva_pkg::cmd_t    cmd;
    fva_pkg::status_t status;

    fva_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (cmd_word.kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    fva_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_word (cmd_word),
        .cmd      (cmd),
        .status   (status),
        .result   (result),
        .done     (done)
    );

endmodule

`default_nettype wire

/* tb/tb_fm_voice_allocator_top.sv */
// Self-checking testbench for fm_voice_allocator_top: directed and random note words
// go through a voice-table scoreboard that predicts every start, stop and silence word.
// Depends on fva_pkg and the RTL of the allocator.
`timescale 1ns / 1ps

module tb_fm_voice_allocator_top;
    import fva_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int ITEM_TARGET   = 1050;
    localparam int SETTLE_CYCLES = 30;
    localparam int SHOWN_ERRORS  = 10;

    class voice_scoreboard;
        note_t     voice_note [VOICES];
        bit        sounding   [VOICES];
        age_t      stamp      [VOICES];
        age_t      age_clock;
        out_word_t expected_q[$];
        int        mismatches;

        function new();
            mismatches = 0;
            clear_table();
        endfunction

        function void clear_table();
            for (int i = 0; i < VOICES; i++)
            begin
                voice_note[i] = '0;
                sounding[i]   = 1'b0;
                stamp[i]      = '0;
            end
            age_clock = '0;
        endfunction

        // Update the voice table for one accepted word; return 1 if it yields a result.
        function bit note_cmd(in_word_t w);
            int        pick;
            age_t      best;
            out_word_t r;
            pick = -1;
            best = '0;
            r    = '0;
            case (kind_t'(w.kind))
                KIND_NOTE_ON:
                begin
                    for (int i = 0; i < VOICES && pick < 0; i++)
                        if (!sounding[i])
                            pick = i;
                    if (pick < 0)
                    begin
                        // steal the oldest voice; only a strictly smaller age moves the pick
                        pick = 0;
                        for (int i = 1; i < VOICES; i++)
                            if (stamp[i] < stamp[pick])
                                pick = i;
                        r.stolen = 1'b1;
                    end
                    age_clock        = age_clock + 1;
                    voice_note[pick] = w.note;
                    sounding[pick]   = 1'b1;
                    stamp[pick]      = age_clock;
                    r.action         = ACT_START;
                    r.voice          = pick[3:0];
                    r.pitch          = w.note;
                end
                KIND_NOTE_OFF:
                begin
                    // newest matching voice wins; ties go to the higher index
                    for (int i = 0; i < VOICES; i++)
                        if (sounding[i] && voice_note[i] == w.note && stamp[i] >= best)
                        begin
                            best = stamp[i];
                            pick = i;
                        end
                    if (pick < 0)
                        return 1'b0;
                    sounding[pick] = 1'b0;
                    r.action       = ACT_STOP;
                    r.voice        = pick[3:0];
                    r.pitch        = w.note;
                end
                KIND_ALL_OFF:
                begin
                    clear_table();
                    r.action = ACT_SILENCE;
                end
                default:
                    return 1'b0;
            endcase
            expected_q.push_back(r);
            return 1'b1;
        endfunction

        function void report(string what, out_word_t want, out_word_t got);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("%0t: %s: expected action %0d voice %0d pitch %0d stolen %0d, ",
                         $realtime, what, want.action, want.voice, want.pitch, want.stolen,
                         "got action %0d voice %0d pitch %0d stolen %0d",
                         got.action, got.voice, got.pitch, got.stolen);
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.action !== want.action || got.voice !== want.voice ||
                got.pitch !== want.pitch || got.stolen !== want.stolen)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  cmd_word;
    out_word_t result;
    logic      done;

    voice_scoreboard sb = new();
    int              stall_cycles = 0;

    fm_voice_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd_word (cmd_word),
        .result   (result),
        .done     (done)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
        if (rst_n && ((start && !busy) || done))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    function automatic in_word_t make_word(kind_t k, int n);
        in_word_t w;
        w.kind = k;
        w.note = n[6:0];
        return w;
    endfunction

    // Keep most notes in a narrow band so note-offs find voices and the table fills up.
    function automatic in_word_t random_word();
        int    roll;
        note_t n;
        roll = $urandom_range(999);
        if ($urandom_range(99) < 80)
            n = note_t'(60 + $urandom_range(7));
        else
            n = note_t'($urandom_range(127));
        if (roll < 550)
            return make_word(KIND_NOTE_ON, n);
        else if (roll < 950)
            return make_word(KIND_NOTE_OFF, n);
        else if (roll < 965)
            return make_word(KIND_ALL_OFF, n);
        else
            return make_word(KIND_UNUSED, n);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input in_word_t w);
        start    <= 1'b1;
        cmd_word <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        void'(sb.note_cmd(w));
        @(negedge clk);
    endtask

    task automatic pace(input bit calm);
        if (!calm)
            while ($urandom_range(99) < 11)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    initial
    begin
        in_word_t directed_q[$];
        int       items;

        rst_n    = 1'b0;
        start    = 1'b0;
        cmd_word = '0;
        items    = 0;

        directed_q = '{
            make_word(KIND_NOTE_OFF, 60),   // nothing sounding yet
            make_word(KIND_UNUSED, 127),
            make_word(KIND_NOTE_ON, 0),
            make_word(KIND_NOTE_ON, 127),
            make_word(KIND_NOTE_ON, 60),
            make_word(KIND_NOTE_ON, 61),
            make_word(KIND_NOTE_ON, 62),
            make_word(KIND_NOTE_ON, 63),
            make_word(KIND_NOTE_ON, 64),
            make_word(KIND_NOTE_ON, 65),
            make_word(KIND_NOTE_ON, 60),    // table full after this one
            make_word(KIND_NOTE_ON, 85),    // steal the oldest voice
            make_word(KIND_NOTE_ON, 86),
            make_word(KIND_NOTE_OFF, 60),   // newer of the two voices on 60
            make_word(KIND_NOTE_OFF, 60),
            make_word(KIND_NOTE_OFF, 60),   // no voice left on 60
            make_word(KIND_NOTE_ON, 42),    // lowest free voice
            make_word(KIND_NOTE_ON, 127),
            make_word(KIND_NOTE_OFF, 127),
            make_word(KIND_UNUSED, 0),
            make_word(KIND_ALL_OFF, 127),
            make_word(KIND_NOTE_ON, 1),
            make_word(KIND_NOTE_OFF, 1),
            make_word(KIND_ALL_OFF, 0)
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_q[i])
        begin
            send_word(directed_q[i]);
            items++;
            pace(1'b0);
        end
        drain();

        while (items < ITEM_TARGET)
        begin
            send_word(random_word());
            items++;
            if (items == ITEM_TARGET / 2)
                drain();
            // hold the sender busy through a long stretch in the middle
            pace(items >= 300 && items < 550);
        end

        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
